// ===== src/ile_pkg.sv =====
package ile_pkg;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 11;
    localparam int CNT_W    = 11;
    localparam int ST_W     = 2;
    localparam int DEPTH_DEF = 1024;

    typedef logic        [OP_W-1:0]   opcode_t;
    typedef logic signed [IDX_W-1:0]  index_t;
    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic        [CNT_W-1:0]  count_t;
    typedef logic        [ST_W-1:0]   status_t;

    // request opcodes
    localparam opcode_t OP_PUSH   = 3'd0;
    localparam opcode_t OP_POP    = 3'd1;
    localparam opcode_t OP_GET    = 3'd2;
    localparam opcode_t OP_FIND   = 3'd3;
    localparam opcode_t OP_INSERT = 3'd4;
    localparam opcode_t OP_REMOVE = 3'd5;

    // result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // position reported when nothing is found
    localparam pos_t POS_NONE = '1;

endpackage

// ===== src/indexed_list_engine.sv =====
// indexed_list_engine: ordered list of signed 32-bit words held in one
// single-port-read, single-port-write store of DEPTH entries.
// Request channel (in_valid/in_stall): opcode, index, value. A word is taken
// at a clock edge with in_valid high and in_stall low. in_stall is high from
// the cycle after a word is taken until the block is back in idle.
// Result channel (out_valid/out_stall): data, position, status, count, one
// result word per request, held in an output register. While out_stall is
// high the result holds and the block may still take the next request; it
// then finishes that request and waits with it until the register frees.
// Steps after a request is taken, ending in S_DONE, which loads the result:
//   push, full/empty/range errors, unused opcodes: straight to S_DONE
//   pop, get, remove past the end: one store read in S_READ
//   find: S_WALK reads from position 0 up to a hit, else on through S_DRAIN
//   insert: shifts entries at and above index up (S_WALK, S_DRAIN), then
//   writes the value (S_FIX); remove: shifts entries above index down
// Requests are handled one at a time: the next word can be taken in the cycle
// after the result loads. A walk steps through the store one entry per cycle
// through its read port.
// Reset clears the entry count and all control state; the store itself is
// not cleared, entries are only read after they were written.
module indexed_list_engine #(
    parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ile_pkg::opcode_t opcode,
    input  ile_pkg::index_t  index,
    input  ile_pkg::word_t   value,
    output logic             out_valid,
    input  logic             out_stall,
    output ile_pkg::word_t   data,
    output ile_pkg::pos_t    position,
    output ile_pkg::status_t status,
    output ile_pkg::count_t  count
);
    import ile_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIX   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // list store
    word_t          mem [DEPTH];
    word_t          mem_q;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    word_t          mem_wdata;

    logic [2:0]     state_reg;
    logic [CW-1:0]  count_reg;
    opcode_t        op_reg;
    word_t          value_reg;
    logic [AW-1:0]  at_reg;
    logic [AW-1:0]  ptr_reg;
    logic [AW-1:0]  last_reg;
    logic           rd_vld_reg;
    logic [AW-1:0]  rd_addr_reg;
    word_t          res_data_reg;
    pos_t           res_pos_reg;
    status_t        res_status_reg;
    logic           out_valid_reg;
    word_t          out_data_reg;
    pos_t           out_pos_reg;
    status_t        out_status_reg;
    count_t         out_count_reg;

    logic            accept;
    logic            out_free;
    logic            full;
    logic            empty;
    logic [CW-1:0]   cm1;
    logic [CMPW-1:0] at_cmp;
    logic            in_rng;
    logic            hit;
    logic            take_rem;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign cm1      = count_reg - CW'(1);

    // negative index clamps to zero
    assign at_cmp = index[IDX_W-1] ? '0
                  : {{(CMPW-IDX_W+1){1'b0}}, index[IDX_W-2:0]};
    assign in_rng = (at_cmp < CMPW'(count_reg));

    // find match on the returning word
    assign hit      = rd_vld_reg && (op_reg == OP_FIND) && (mem_q == value_reg);
    assign take_rem = rd_vld_reg && (op_reg == OP_REMOVE) && (rd_addr_reg == at_reg);

    // store port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = rd_addr_reg;
        mem_wdata = mem_q;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((opcode == OP_PUSH || opcode == OP_INSERT) && !full
                        && !(opcode == OP_INSERT && in_rng))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = count_reg[AW-1:0];
                        mem_wdata = value;
                    end
                    else if ((opcode == OP_POP || (opcode == OP_REMOVE && !in_rng))
                             && !empty)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = cm1[AW-1:0];
                    end
                    else if (opcode == OP_GET && !index[IDX_W-1] && in_rng)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = at_cmp[AW-1:0];
                    end
                end
            end
            S_WALK, S_DRAIN:
            begin
                mem_re = (state_reg == S_WALK);
                if (rd_vld_reg && op_reg == OP_INSERT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg + AW'(1);
                end
                else if (rd_vld_reg && op_reg == OP_REMOVE && !take_rem)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg - AW'(1);
                end
            end
            S_FIX:
            begin
                mem_we    = 1'b1;
                mem_waddr = at_reg;
                mem_wdata = value_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= OP_PUSH;
            value_reg      <= '0;
            at_reg         <= '0;
            ptr_reg        <= '0;
            last_reg       <= '0;
            rd_addr_reg    <= '0;
            res_data_reg   <= '0;
            res_pos_reg    <= POS_NONE;
            res_status_reg <= ST_OK;
            out_data_reg   <= '0;
            out_pos_reg    <= POS_NONE;
            out_status_reg <= ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= ptr_reg;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= opcode;
                        value_reg      <= value;
                        at_reg         <= at_cmp[AW-1:0];
                        res_data_reg   <= '0;
                        res_pos_reg    <= POS_NONE;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DONE;
                        unique case (opcode)
                            OP_PUSH:
                            begin
                                if (full)
                                    res_status_reg <= ST_FULL;
                                else
                                    count_reg <= count_reg + CW'(1);
                            end
                            OP_POP:
                            begin
                                if (empty)
                                    res_status_reg <= ST_RANGE;
                                else
                                begin
                                    count_reg <= cm1;
                                    state_reg <= S_READ;
                                end
                            end
                            OP_GET:
                            begin
                                if (index[IDX_W-1] || !in_rng)
                                    res_status_reg <= ST_RANGE;
                                else
                                    state_reg <= S_READ;
                            end
                            OP_FIND:
                            begin
                                if (!empty)
                                begin
                                    ptr_reg   <= '0;
                                    last_reg  <= cm1[AW-1:0];
                                    state_reg <= S_WALK;
                                end
                            end
                            OP_INSERT:
                            begin
                                if (full)
                                    res_status_reg <= ST_FULL;
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                    if (in_rng)
                                    begin
                                        ptr_reg   <= cm1[AW-1:0];
                                        last_reg  <= at_cmp[AW-1:0];
                                        state_reg <= S_WALK;
                                    end
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (in_rng)
                                begin
                                    count_reg <= cm1;
                                    ptr_reg   <= at_cmp[AW-1:0];
                                    last_reg  <= cm1[AW-1:0];
                                    state_reg <= S_WALK;
                                end
                                else if (empty)
                                    res_status_reg <= ST_RANGE;
                                else
                                begin
                                    count_reg <= cm1;
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    res_data_reg <= mem_q;
                    state_reg    <= S_DONE;
                end
                S_WALK:
                begin
                    if (take_rem)
                        res_data_reg <= mem_q;
                    if (hit)
                    begin
                        res_pos_reg <= POS_W'(rd_addr_reg);
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b1;
                        if (ptr_reg == last_reg)
                            state_reg <= S_DRAIN;
                        else if (op_reg == OP_INSERT)
                            ptr_reg <= ptr_reg - AW'(1);
                        else
                            ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (take_rem)
                        res_data_reg <= mem_q;
                    if (hit)
                        res_pos_reg <= POS_W'(rd_addr_reg);
                    state_reg <= (op_reg == OP_INSERT) ? S_FIX : S_DONE;
                end
                S_FIX:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_data_reg   <= res_data_reg;
                        out_pos_reg    <= res_pos_reg;
                        out_status_reg <= res_status_reg;
                        out_count_reg  <= CNT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign position  = out_pos_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

    // entry count stays within capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // shifting never writes the entry being read in the same cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store read and write hit the same entry");

    // no read left in flight once back in idle
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rd_vld_reg)
        else $error("pending read while idle");

    // a taken request always raises in_stall in the cycle after
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request taken without leaving idle");

    // a result word is loaded only from the finishing state
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside the finishing state");

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int LIST_CAP = DEPTH_DEF;
    // length of the long list used for deep finds and shifts
    localparam int GROW_TO  = 160;

    // opcodes the block leaves unused
    localparam opcode_t OP_SPARE_A = 3'd6;
    localparam opcode_t OP_SPARE_B = 3'd7;

    // one result word as the list should report it
    typedef struct {
        opcode_t op;
        word_t   data;
        pos_t    position;
        status_t status;
        count_t  count;
    } list_reply_t;

    // shadow copy of the list, predicts each result word and checks it
    class list_mirror;
        localparam int CAP = DEPTH_DEF;

        word_t       entries [CAP];
        int          used;
        int          peak;
        int unsigned op_seen [8];
        int unsigned checked;
        int unsigned mismatches;
        list_reply_t awaited [$];

        function bit append(word_t val);
            if (used >= CAP)
                return 1'b0;
            entries[used] = val;
            used++;
            return 1'b1;
        endfunction

        function bit drop(output word_t val);
            val = '0;
            if (used == 0)
                return 1'b0;
            used--;
            val = entries[used];
            return 1'b1;
        endfunction

        // accepted request word: update the list and queue its result
        function void take_request(opcode_t op, index_t idx, word_t val);
            list_reply_t r;
            int at;
            r.op = op;
            r.data = '0;
            r.position = POS_NONE;
            r.status = ST_OK;
            at = (idx < 0) ? 0 : int'(idx);
            op_seen[op]++;
            case (op)
                OP_PUSH:
                begin
                    if (!append(val))
                        r.status = ST_FULL;
                end
                OP_POP:
                begin
                    if (!drop(r.data))
                        r.status = ST_RANGE;
                end
                OP_GET:
                begin
                    if (idx < 0 || at >= used)
                        r.status = ST_RANGE;
                    else
                        r.data = entries[at];
                end
                OP_FIND:
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        if (entries[i] == val)
                        begin
                            r.position = pos_t'(i);
                            break;
                        end
                    end
                end
                OP_INSERT:
                begin
                    // past the end behaves as an append
                    if (at >= used)
                    begin
                        if (!append(val))
                            r.status = ST_FULL;
                    end
                    else if (used >= CAP)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = used; i > at; i--)
                            entries[i] = entries[i-1];
                        entries[at] = val;
                        used++;
                    end
                end
                OP_REMOVE:
                begin
                    // past the end behaves as a pop
                    if (at >= used)
                    begin
                        if (!drop(r.data))
                            r.status = ST_RANGE;
                    end
                    else
                    begin
                        r.data = entries[at];
                        for (int i = at; i + 1 < used; i++)
                            entries[i] = entries[i+1];
                        used--;
                    end
                end
                default:
                    ;
            endcase
            if (used > peak)
                peak = used;
            r.count = count_t'(used);
            awaited.push_back(r);
        endfunction

        function void compare_field(opcode_t op, string field, logic [31:0] want,
                                    logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: opcode %0d %s expected 0x%0h, got 0x%0h",
                         $time, op, field, want, got);
            end
        endfunction

        // result word from the block against the oldest prediction
        function void match_result(word_t d, pos_t p, status_t s, count_t c);
            list_reply_t r;
            checked++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with nothing outstanding, %s 0x%0h count %0d",
                         $time, "expected none, got data", d, c);
                return;
            end
            r = awaited.pop_front();
            compare_field(r.op, "data", 32'(r.data), 32'(d));
            compare_field(r.op, "position", 32'(r.position), 32'(p));
            compare_field(r.op, "status", 32'(r.status), 32'(s));
            compare_field(r.op, "count", 32'(r.count), 32'(c));
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    opcode_t opcode = OP_PUSH;
    index_t  index = '0;
    word_t   value = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    word_t   data;
    pos_t    position;
    status_t status;
    count_t  count;

    int gap_pct = 0;
    int stall_pct = 0;

    list_mirror shadow;

    indexed_list_engine #(
        .DEPTH(LIST_CAP)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .index(index),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data(data),
        .position(position),
        .status(status),
        .count(count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: check taken words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            shadow.match_result(data, position, status, count);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // request side: optional idle cycles, then hold the word until taken
    task automatic send_word(input opcode_t op, input index_t idx, input word_t val);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        index <= idx;
        value <= val;
        do
            @(posedge clk);
        while (in_stall);
        shadow.take_request(op, idx, val);
    endtask

    // hold off requests until every result word is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.awaited.size() != 0);
    endtask

    function automatic opcode_t pick_op(int target);
        int unsigned roll;
        opcode_t op;
        roll = $urandom_range(99);
        if (roll < 20)
            op = OP_PUSH;
        else if (roll < 32)
            op = OP_POP;
        else if (roll < 50)
            op = OP_GET;
        else if (roll < 67)
            op = OP_FIND;
        else if (roll < 82)
            op = OP_INSERT;
        else if (roll < 96)
            op = OP_REMOVE;
        else if (roll < 98)
            op = OP_SPARE_A;
        else
            op = OP_SPARE_B;
        // steer occupancy toward the target
        if ($urandom_range(1) == 1)
        begin
            if (shadow.used > target && op == OP_PUSH)
                op = OP_POP;
            else if (shadow.used > target && op == OP_INSERT)
                op = OP_REMOVE;
            else if (shadow.used < target && op == OP_POP)
                op = OP_PUSH;
            else if (shadow.used < target && op == OP_REMOVE)
                op = OP_INSERT;
        end
        return op;
    endfunction

    // mostly in range, some at or past the end, some negative or arbitrary
    function automatic index_t pick_index();
        int u;
        u = shadow.used;
        case ($urandom_range(9))
            0: return index_t'($urandom);
            1: return index_t'(-int'($urandom_range(1, 32768)));
            2: return index_t'(u + int'($urandom_range(0, 3)));
            default: return index_t'($urandom_range(0, u));
        endcase
    endfunction

    // stored words often, so find hits and duplicates show up
    function automatic word_t pick_value();
        word_t corners [5];
        int unsigned roll;
        corners = '{32'sh0, -32'sh1, 32'sh7fffffff, 32'sh80000000, 32'sh7};
        roll = $urandom_range(99);
        if (roll < 30 && shadow.used > 0)
            return shadow.entries[$urandom_range(0, shadow.used - 1)];
        else if (roll < 45)
            return corners[$urandom_range(0, 4)];
        return word_t'($urandom);
    endfunction

    task automatic run_random(int items, int gap, int stall);
        int target;
        target = 0;
        gap_pct = gap;
        stall_pct = stall;
        for (int n = 0; n < items; n++)
        begin
            if (n % 40 == 0)
                target = $urandom_range(0, 48);
            send_word(pick_op(target), pick_index(), pick_value());
        end
        drain_results();
    endtask

    initial
    begin
        shadow = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corners
        send_word(OP_POP, 16'sd0, 32'sd0);
        send_word(OP_GET, 16'sd0, 32'sd0);
        send_word(OP_REMOVE, 16'sd5, 32'sd0);
        send_word(OP_FIND, 16'sd0, 32'sd0);
        send_word(OP_SPARE_A, -16'sd1, -32'sd1);
        send_word(OP_SPARE_B, 16'sh7fff, 32'sh7fffffff);

        // extreme words, clamped and appending inserts, middle insert
        send_word(OP_PUSH, 16'sd0, 32'sh7fffffff);
        send_word(OP_PUSH, 16'sd0, 32'sh80000000);
        send_word(OP_PUSH, 16'sd0, 32'sd0);
        send_word(OP_PUSH, 16'sd0, -32'sd1);
        send_word(OP_INSERT, 16'sh8000, 32'sd1234);
        send_word(OP_INSERT, 16'sh7fff, 32'sd5);
        send_word(OP_INSERT, 16'sd2, 32'sh55555555);

        // gets in and out of range, finds hit and miss
        send_word(OP_GET, -16'sd1, 32'sd0);
        send_word(OP_GET, 16'sh7fff, 32'sd0);
        send_word(OP_GET, 16'sd6, 32'sd0);
        send_word(OP_GET, 16'sd0, 32'sd0);
        send_word(OP_FIND, 16'sd0, 32'sh80000000);
        send_word(OP_FIND, 16'sd0, 32'sh12345678);

        // clamped remove, remove past the end, middle remove, pop
        send_word(OP_REMOVE, -16'sd5, 32'sd0);
        send_word(OP_REMOVE, 16'sh7fff, 32'sd0);
        send_word(OP_REMOVE, 16'sd1, 32'sd0);
        send_word(OP_POP, 16'sd0, 32'sd0);
        drain_results();

        // grow a long list, mostly appends with short inserts near the tail
        gap_pct = 15;
        stall_pct = 15;
        while (shadow.used < GROW_TO)
        begin
            if ($urandom_range(9) == 0 && shadow.used > 4)
                send_word(OP_INSERT, index_t'(shadow.used - int'($urandom_range(1, 4))),
                          word_t'($urandom));
            else
                send_word(OP_PUSH, index_t'($urandom), word_t'($urandom));
        end

        // long list: deep finds and shifts across the whole list
        gap_pct = 0;
        stall_pct = 0;
        send_word(OP_FIND, 16'sd0, shadow.entries[GROW_TO-1]);
        send_word(OP_FIND, 16'sd0, shadow.entries[GROW_TO/2]);
        send_word(OP_FIND, 16'sd0, word_t'($urandom));
        send_word(OP_GET, index_t'(GROW_TO - 1), 32'sd0);
        send_word(OP_INSERT, 16'sd0, 32'sh0badcafe);
        send_word(OP_REMOVE, 16'sd1, 32'sd0);
        send_word(OP_REMOVE, -16'sd3, 32'sd0);
        send_word(OP_INSERT, 16'sh7fff, 32'sd99);
        drain_results();

        // shrink back to a short list
        gap_pct = 15;
        stall_pct = 15;
        while (shadow.used > 40)
        begin
            if ($urandom_range(7) == 0)
                send_word(OP_REMOVE, index_t'(shadow.used - int'($urandom_range(1, 3))),
                          32'sd0);
            else
                send_word(OP_POP, 16'sd0, 32'sd0);
        end
        drain_results();

        // random phases with different idle and stall mixes
        run_random(67, 0, 0);
        run_random(67, 48, 0);
        run_random(67, 0, 48);
        run_random(67, 15, 15);

        drain_results();
        repeat (LIST_CAP + 16) @(posedge clk);

        $display("covered %0d requests: push %0d pop %0d get %0d find %0d",
                 shadow.op_seen.sum(), shadow.op_seen[OP_PUSH], shadow.op_seen[OP_POP],
                 shadow.op_seen[OP_GET], shadow.op_seen[OP_FIND]);
        $display("  insert %0d remove %0d unused %0d, %0d result words checked, peak %0d",
                 shadow.op_seen[OP_INSERT], shadow.op_seen[OP_REMOVE],
                 shadow.op_seen[OP_SPARE_A] + shadow.op_seen[OP_SPARE_B],
                 shadow.checked, shadow.peak);
        if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("timeout with %0d result words outstanding", shadow.awaited.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
